### rtl/gain_ladder_blend_weight_core_defines.svh
// ----------------------------------------------------------------------------
// Gain ladder blend weight assertion macros
// Shared assertion forms for the checker of the blend weight core.
// ----------------------------------------------------------------------------
`ifndef GAIN_LADDER_BLEND_WEIGHT_CORE_DEFINES_SVH
`define GAIN_LADDER_BLEND_WEIGHT_CORE_DEFINES_SVH

// Assertion that is switched off while the reset is active.
`define GLBW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while the reset is active.
`define GLBW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/glbw_pkg.sv
// ----------------------------------------------------------------------------
// Gain ladder blend weight package
// Shared constants, the stage record and the float32 bound decoder.
// ----------------------------------------------------------------------------
package glbw_pkg;

  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned BOUND_BITS     = 32;
  localparam int unsigned NUM_BOUND_REGS = 8;
  localparam int unsigned NUM_BANDS      = 4;
  localparam int unsigned BAND_BITS      = 2;

  localparam logic [7:0] EXP_BIAS  = 8'd127;
  localparam logic [7:0] MAX_EXP   = 8'd30;
  localparam logic [7:0] MANT_BITS = 8'd23;

  typedef struct packed {
    logic [BAND_BITS-1:0]  band_index;
    logic [BOUND_BITS-1:0] band_low;
    logic [BOUND_BITS-1:0] band_high;
    logic                  force_one;
    logic                  force_zero;
    logic [BOUND_BITS-1:0] rem;
    logic [BOUND_BITS-1:0] den;
  } glbw_stage_t;

  function automatic logic [BOUND_BITS-1:0] decode_bound(input logic [CFG_DATA_BITS-1:0] bits);
    logic [7:0]            expo;
    logic [BOUND_BITS-1:0] mant;
    logic [BOUND_BITS-1:0] res;
    expo = bits[30:23];
    mant = {8'd0, 1'b1, bits[22:0]};
    if (bits[31] || (expo < EXP_BIAS)) begin
      res = '0;
    end else if (expo > (EXP_BIAS + MAX_EXP)) begin
      res = '1;
    end else if (expo >= (EXP_BIAS + MANT_BITS)) begin
      res = mant << (expo - (EXP_BIAS + MANT_BITS));
    end else begin
      res = mant >> ((EXP_BIAS + MANT_BITS) - expo);
    end
    return res;
  endfunction

endpackage

### rtl/glbw_if.sv
// ----------------------------------------------------------------------------
// Gain ladder blend weight interfaces
// Valid/ready channels for configuration writes, gains and results.
// ----------------------------------------------------------------------------
interface glbw_cfg_if;
  import glbw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface glbw_gain_if #(
  parameter int unsigned GAIN_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [GAIN_BITS-1:0] sensor_gain;

  modport source (output valid, output sensor_gain, input ready);
  modport sink   (input valid, input sensor_gain, output ready);
endinterface

interface glbw_result_if #(
  parameter int unsigned WEIGHT_FRACTION_BITS = 16
);
  import glbw_pkg::*;

  logic                            valid;
  logic                            ready;
  logic [BAND_BITS-1:0]            band_index;
  logic [WEIGHT_FRACTION_BITS:0]   low_weight;
  logic [BOUND_BITS-1:0]           band_low;
  logic [BOUND_BITS-1:0]           band_high;

  modport source (output valid, output band_index, output low_weight,
                  output band_low, output band_high, input ready);
  modport sink   (input valid, input band_index, input low_weight,
                  input band_low, input band_high, output ready);
endinterface

### rtl/glbw_band_select.sv
// ----------------------------------------------------------------------------
// Gain ladder band select
// Holds the decoded ladder bounds, picks the band for a gain and registers
// the band bounds, the special-case flags and the division operands.
// ----------------------------------------------------------------------------
module glbw_band_select #(
  parameter int unsigned GAIN_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  glbw_cfg_if.sink              cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [GAIN_BITS-1:0]  gain_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output glbw_pkg::glbw_stage_t data_o
);
  import glbw_pkg::*;

  logic [BOUND_BITS-1:0] upper_q [NUM_BANDS];
  logic [BOUND_BITS-1:0] lower_q [NUM_BANDS];
  logic                  cfg_hit;
  logic [BOUND_BITS-1:0] cfg_dec;
  logic [BOUND_BITS-1:0] gain_ext;
  logic [NUM_BANDS-1:0]  pass;
  logic [BAND_BITS-1:0]  band;
  logic [BOUND_BITS-1:0] lo;
  logic [BOUND_BITS-1:0] hi;
  glbw_stage_t           stage_d;
  glbw_stage_t           stage_q;
  logic                  valid_d;
  logic                  valid_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_hit = cfg_i.valid && (cfg_i.index < CFG_INDEX_BITS'(NUM_BOUND_REGS));
  assign cfg_dec = decode_bound(cfg_i.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        upper_q[i] <= '0;
        lower_q[i] <= '0;
      end
    end else if (cfg_hit) begin
      if (cfg_i.index[BAND_BITS]) begin
        lower_q[cfg_i.index[BAND_BITS-1:0]] <= cfg_dec;
      end else begin
        upper_q[cfg_i.index[BAND_BITS-1:0]] <= cfg_dec;
      end
    end
  end

  assign gain_ext = BOUND_BITS'(gain_i);

  always_comb begin
    for (int i = 0; i < NUM_BANDS; i++) begin
      pass[i] = gain_ext >= upper_q[i];
    end
  end

  always_comb begin
    priority if (&pass) begin
      band = 2'd3;
    end else if (&pass[2:0]) begin
      band = 2'd2;
    end else if (&pass[1:0]) begin
      band = 2'd1;
    end else begin
      band = 2'd0;
    end
  end

  assign lo = upper_q[band];
  assign hi = lower_q[band];

  always_comb begin
    stage_d.band_index = band;
    stage_d.band_low   = lo;
    stage_d.band_high  = hi;
    stage_d.force_one  = (gain_ext <= lo) || (hi <= lo);
    stage_d.force_zero = gain_ext >= hi;
    stage_d.rem        = gain_ext - lo;
    stage_d.den        = hi - lo;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = stage_q;

endmodule

### rtl/glbw_div_cell.sv
// ----------------------------------------------------------------------------
// Gain ladder divider cell
// One restoring division step: produces one quotient bit of the band
// fraction and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module glbw_div_cell #(
  parameter int unsigned QUOT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  glbw_pkg::glbw_stage_t data_i,
  input  logic [QUOT_BITS-1:0]  quot_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output glbw_pkg::glbw_stage_t data_o,
  output logic [QUOT_BITS-1:0]  quot_o
);
  import glbw_pkg::*;

  logic [BOUND_BITS:0]    shifted;
  logic [BOUND_BITS:0]    diff;
  logic                   fits;
  glbw_stage_t            data_d;
  glbw_stage_t            data_q;
  logic [QUOT_BITS-1:0]   quot_d;
  logic [QUOT_BITS-1:0]   quot_q;
  logic                   valid_d;
  logic                   valid_q;

  always_comb begin
    shifted = {data_i.rem, 1'b0};
    diff    = shifted - {1'b0, data_i.den};
    fits    = shifted >= {1'b0, data_i.den};
    data_d  = data_i;
    data_d.rem = fits ? diff[BOUND_BITS-1:0] : shifted[BOUND_BITS-1:0];
    quot_d  = {quot_i[QUOT_BITS-2:0], fits};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      quot_q <= quot_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign quot_o  = quot_q;

endmodule

### rtl/gain_ladder_blend_weight_core.sv
// ----------------------------------------------------------------------------
// Gain ladder blend weight core
// Takes one sensor gain per transaction and returns the ladder band and the
// Q-format weight of its low entry. One gain is accepted every clock cycle
// while results are taken at the output; the path is one band-select
// register stage followed by a row of WEIGHT_FRACTION_BITS divider cells,
// each producing one quotient bit. Each stage stalls only when the stage
// after it is full, so bubbles close up while a result waits at the output.
// Configuration writes are taken in any cycle, decode the float32 bound at
// once, and must only be made while no gain is in flight; indexes beyond the
// eight bound registers are ignored.
// ----------------------------------------------------------------------------
module gain_ladder_blend_weight_core #(
  parameter int unsigned GAIN_BITS            = 16,
  parameter int unsigned WEIGHT_FRACTION_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  glbw_cfg_if.sink       cfg_i,
  glbw_gain_if.sink      gain_i,
  glbw_result_if.source  result_o
);
  import glbw_pkg::*;

  localparam int unsigned NUM_CELLS = WEIGHT_FRACTION_BITS;
  localparam logic [WEIGHT_FRACTION_BITS:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRACTION_BITS{1'b0}}};

  glbw_stage_t                     stage_data  [NUM_CELLS+1];
  logic [WEIGHT_FRACTION_BITS-1:0] stage_quot  [NUM_CELLS+1];
  logic                            stage_valid [NUM_CELLS+1];
  logic                            stage_ready [NUM_CELLS+1];
  glbw_stage_t                     last;

  glbw_band_select #(
    .GAIN_BITS (GAIN_BITS)
  ) u_band_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .valid_i (gain_i.valid),
    .ready_o (gain_i.ready),
    .gain_i  (gain_i.sensor_gain),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .data_o  (stage_data[0])
  );

  assign stage_quot[0] = '0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    glbw_div_cell #(
      .QUOT_BITS (WEIGHT_FRACTION_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .ready_o (stage_ready[k]),
      .data_i  (stage_data[k]),
      .quot_i  (stage_quot[k]),
      .valid_o (stage_valid[k+1]),
      .ready_i (stage_ready[k+1]),
      .data_o  (stage_data[k+1]),
      .quot_o  (stage_quot[k+1])
    );
  end

  assign stage_ready[NUM_CELLS] = result_o.ready;
  assign last = stage_data[NUM_CELLS];

  assign result_o.valid      = stage_valid[NUM_CELLS];
  assign result_o.band_index = last.band_index;
  assign result_o.band_low   = last.band_low;
  assign result_o.band_high  = last.band_high;

  always_comb begin
    priority if (last.force_one) begin
      result_o.low_weight = WEIGHT_ONE;
    end else if (last.force_zero) begin
      result_o.low_weight = '0;
    end else begin
      result_o.low_weight = WEIGHT_ONE - {1'b0, stage_quot[NUM_CELLS]};
    end
  end

endmodule

### rtl/glbw_checker.sv
// ----------------------------------------------------------------------------
// Gain ladder blend weight checker
// Port-level assertions for the blend weight core, attached by bind.
// ----------------------------------------------------------------------------
`include "gain_ladder_blend_weight_core_defines.svh"

module glbw_checker #(
  parameter int unsigned WEIGHT_FRACTION_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [WEIGHT_FRACTION_BITS:0] low_weight_i
);

  localparam logic [WEIGHT_FRACTION_BITS:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRACTION_BITS{1'b0}}};

  `GLBW_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_i, "Result valid during reset.")
  `GLBW_ASSERT(a_weight_range, clk_i, rst_ni, out_valid_i |-> (low_weight_i <= WEIGHT_ONE), "Low weight above one.")
  `GLBW_ASSERT(a_cfg_always_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_i, "Configuration write stalled.")
  `GLBW_ASSERT(a_result_held, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i, "Result withdrawn before transaction.")

endmodule

bind gain_ladder_blend_weight_core glbw_checker #(
  .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
) u_glbw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .low_weight_i (result_o.low_weight)
);
